// ===== hw/rtl/ipv4_header_parse_check_macros.svh =====
// ----------------------------------------------------------------------------
// ipv4 header parse check assertion macros
// shared clocked assertion forms, disabled while in reset
// ----------------------------------------------------------------------------
`ifndef IPV4_HEADER_PARSE_CHECK_MACROS_SVH
`define IPV4_HEADER_PARSE_CHECK_MACROS_SVH

// property on clk, checked outside reset
`define IHPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication with the consequent in the cycle after the antecedent
`define IHPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ihpc_pkg.sv =====
// ----------------------------------------------------------------------------
// ihpc_pkg
// types and constants for the ipv4 header parser and checksum check
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ihpc_pkg;

    localparam int POS_W = 6;

    // header byte at which version and ihl are judged
    localparam logic [POS_W-1:0] POS_HDR_CHECK = 6'd19;

    localparam logic [3:0]  IP_VERSION = 4'd4;
    localparam logic [3:0]  MIN_IHL    = 4'd5;
    localparam logic [15:0] SUM_GOOD   = 16'hFFFF;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_BAD_CHECKSUM = 2'd1,
        STATUS_BAD_HEADER   = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_packet;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  version;
        logic [3:0]  header_words;
        logic [7:0]  service_type;
        logic [15:0] total_length;
        logic [15:0] ident;
        logic [2:0]  frag_flags;
        logic [12:0] frag_offset;
        logic [7:0]  time_to_live;
        logic [7:0]  protocol_number;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        status_t     status;
    } out_word_t;

    // result handed from parser to output stage
    typedef struct packed {
        logic      valid;
        out_word_t word;
    } result_t;

endpackage

// ===== hw/rtl/ipv4_header_parse_check.sv =====
// ----------------------------------------------------------------------------
// ipv4_header_parse_check: ipv4 header parser with header checksum check
// result: the word is registered into the output stage when the parser ends a header
// throughput: one byte per cycle while the output skid entry is free (byte_ready high)
// reset: rst_n clears position and header state; the block starts idle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipv4_header_parse_check (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  ihpc_pkg::in_word_t  byte_word,
    output logic                result_valid,
    input  logic                result_ready,
    output ihpc_pkg::out_word_t result_word
);

    ihpc_pkg::result_t result;
    logic              accept;

    assign accept = byte_valid & byte_ready;

    ihpc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .byte_word (byte_word),
        .result    (result)
    );

    ihpc_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .space     (byte_ready),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_word  (result_word)
    );

endmodule

// ===== hw/rtl/ihpc_parser.sv =====
// ----------------------------------------------------------------------------
// ihpc_parser
// byte position tracking, header field capture and ones' complement sum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ipv4_header_parse_check_macros.svh"

module ihpc_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  ihpc_pkg::in_word_t byte_word,
    output ihpc_pkg::result_t  result
);

    logic                      in_header_reg, in_header_next;
    logic [ihpc_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [15:0]               sum_reg, sum_next;
    logic [7:0]                high_reg, high_next;
    logic [3:0]                version_reg, version_next;
    logic [3:0]                ihl_reg, ihl_next;
    logic [7:0]                service_reg, service_next;
    logic [15:0]               length_reg, length_next;
    logic [15:0]               ident_reg, ident_next;
    logic [15:0]               flags_offset_reg, flags_offset_next;
    logic [7:0]                ttl_reg, ttl_next;
    logic [7:0]                protocol_reg, protocol_next;
    logic [31:0]               source_reg, source_next;
    logic [31:0]               dest_reg, dest_next;

    logic                      sop;
    logic                      active;
    logic [7:0]                b;
    logic [ihpc_pkg::POS_W-1:0] pos;
    logic [15:0]               sum_base;
    logic [16:0]               wide_sum;
    logic                      bad_header;
    logic                      header_done;

    always_comb
    begin
        b        = byte_word.data_byte;
        sop      = byte_word.start_of_packet;
        active   = accept & (sop | in_header_reg);
        pos      = sop ? '0 : pos_reg;
        sum_base = sop ? 16'd0 : sum_reg;
        wide_sum = {1'b0, sum_base} + {1'b0, high_reg, b};

        in_header_next    = in_header_reg;
        pos_next          = pos_reg;
        sum_next          = sum_reg;
        high_next         = high_reg;
        version_next      = version_reg;
        ihl_next          = ihl_reg;
        service_next      = service_reg;
        length_next       = length_reg;
        ident_next        = ident_reg;
        flags_offset_next = flags_offset_reg;
        ttl_next          = ttl_reg;
        protocol_next     = protocol_reg;
        source_next       = source_reg;
        dest_next         = dest_reg;
        bad_header        = 1'b0;
        header_done       = 1'b0;

        if (active)
        begin
            // even position holds the high byte, odd position folds the word in
            if (!pos[0])
            begin
                high_next = b;
                sum_next  = sum_base;
            end
            else
            begin
                sum_next = wide_sum[15:0] + {15'd0, wide_sum[16]};
            end

            unique case (pos) inside
                6'd0:
                begin
                    version_next = b[7:4];
                    ihl_next     = b[3:0];
                end
                6'd1:           service_next      = b;
                6'd2, 6'd3:     length_next       = {length_reg[7:0], b};
                6'd4, 6'd5:     ident_next        = {ident_reg[7:0], b};
                6'd6, 6'd7:     flags_offset_next = {flags_offset_reg[7:0], b};
                6'd8:           ttl_next          = b;
                6'd9:           protocol_next     = b;
                [6'd12:6'd15]:  source_next       = {source_reg[23:0], b};
                [6'd16:6'd19]:  dest_next         = {dest_reg[23:0], b};
                default:        ;
            endcase

            bad_header  = (pos == ihpc_pkg::POS_HDR_CHECK)
                        && ((version_next != ihpc_pkg::IP_VERSION)
                            || (ihl_next < ihpc_pkg::MIN_IHL));
            // last header byte sits at position ihl*4-1
            header_done = (pos >= ihpc_pkg::POS_HDR_CHECK)
                        && (pos == {ihl_next - 4'd1, 2'b11});

            if (bad_header || header_done)
            begin
                in_header_next = 1'b0;
                pos_next       = pos;
            end
            else
            begin
                in_header_next = 1'b1;
                pos_next       = pos + ihpc_pkg::POS_W'(1);
            end
        end
    end

    always_comb
    begin
        result.valid                    = bad_header | header_done;
        result.word.version             = version_next;
        result.word.header_words        = ihl_next;
        result.word.service_type        = service_next;
        result.word.total_length        = length_next;
        result.word.ident               = ident_next;
        result.word.frag_flags          = flags_offset_next[15:13];
        result.word.frag_offset         = flags_offset_next[12:0];
        result.word.time_to_live        = ttl_next;
        result.word.protocol_number     = protocol_next;
        result.word.source_address      = source_next;
        result.word.destination_address = dest_next;
        if (bad_header)
            result.word.status = ihpc_pkg::STATUS_BAD_HEADER;
        else if (sum_next == ihpc_pkg::SUM_GOOD)
            result.word.status = ihpc_pkg::STATUS_OK;
        else
            result.word.status = ihpc_pkg::STATUS_BAD_CHECKSUM;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_header_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            in_header_reg <= in_header_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg          <= sum_next;
        high_reg         <= high_next;
        version_reg      <= version_next;
        ihl_reg          <= ihl_next;
        service_reg      <= service_next;
        length_reg       <= length_next;
        ident_reg        <= ident_next;
        flags_offset_reg <= flags_offset_next;
        ttl_reg          <= ttl_next;
        protocol_reg     <= protocol_next;
        source_reg       <= source_next;
        dest_reg         <= dest_next;
    end

    `IHPC_ASSERT_NEXT(a_result_ends_header, result.valid, !in_header_reg, "header still open after result")
    `IHPC_ASSERT(a_ok_needs_good_header, (result.valid && result.word.status != ihpc_pkg::STATUS_BAD_HEADER) |-> (result.word.version == ihpc_pkg::IP_VERSION && result.word.header_words >= ihpc_pkg::MIN_IHL), "non header error result with bad version or ihl")
    `IHPC_ASSERT(a_pos_in_header, in_header_reg |-> (pos_reg <= {ihl_reg, 2'b11} || pos_reg <= ihpc_pkg::POS_HDR_CHECK), "byte position past header end")

endmodule

// ===== hw/rtl/ihpc_out_stage.sv =====
// ----------------------------------------------------------------------------
// ihpc_out_stage
// result register with one skid entry behind it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ipv4_header_parse_check_macros.svh"

module ihpc_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  ihpc_pkg::result_t   result,
    output logic                space,
    output logic                out_valid,
    input  logic                out_ready,
    output ihpc_pkg::out_word_t out_word
);

    logic                main_valid_reg, main_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    ihpc_pkg::out_word_t main_word_reg, main_word_next;
    ihpc_pkg::out_word_t skid_word_reg, skid_word_next;

    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_word  = main_word_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_word_next  = main_word_reg;
        skid_word_next  = skid_word_reg;
        if (skid_valid_reg)
        begin
            // no new word can arrive while the skid entry is full
            if (out_ready)
            begin
                main_word_next  = skid_word_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (result.valid)
        begin
            if (!main_valid_reg || out_ready)
            begin
                main_valid_next = 1'b1;
                main_word_next  = result.word;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_word_next  = result.word;
            end
        end
        else if (out_ready)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_word_reg <= main_word_next;
        skid_word_reg <= skid_word_next;
    end

    `IHPC_ASSERT(a_skid_behind_main, skid_valid_reg |-> main_valid_reg, "skid entry full with result register empty")
    `IHPC_ASSERT(a_no_push_when_full, skid_valid_reg |-> !result.valid, "word pushed into full output stage")
    `IHPC_ASSERT_NEXT(a_skid_drains, (skid_valid_reg && out_ready), (main_valid_reg && !skid_valid_reg), "skid entry did not move up")

endmodule

// ===== dv/tb_ipv4_header_parse_check.sv =====
// ----------------------------------------------------------------------------
// tb_ipv4_header_parse_check: testbench for the ipv4 header parser
// feeds whole and broken ipv4 headers a byte per word, predicts each header
// word with its own byte-level parser and compares every field of the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ipv4_header_parse_check;

    localparam int CYCLE_LIMIT         = 200000;
    localparam int HDR_BYTES_PER_PHASE = 120;
    localparam int HEADERS_PER_PHASE   = 4;

    // byte-level header parser and the queue of header words still due
    class header_scoreboard;
        logic [5:0]  pos;
        bit          in_hdr;
        logic [15:0] csum_acc;
        logic [7:0]  hi_byte;
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [7:0]  tos;
        logic [15:0] tot_len;
        logic [15:0] ident;
        logic [15:0] flg_off;
        logic [7:0]  ttl;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
        ihpc_pkg::out_word_t headers_due[$];
        int          errors;
        int          predicted;

        function new();
            pos       = '0;
            in_hdr    = 1'b0;
            csum_acc  = '0;
            hi_byte   = '0;
            ver       = '0;
            ihl       = '0;
            tos       = '0;
            tot_len   = '0;
            ident     = '0;
            flg_off   = '0;
            ttl       = '0;
            proto     = '0;
            src       = '0;
            dst       = '0;
            errors    = 0;
            predicted = 0;
        endfunction

        function ihpc_pkg::out_word_t capture(ihpc_pkg::status_t st);
            ihpc_pkg::out_word_t w;
            w.version             = ver;
            w.header_words        = ihl;
            w.service_type        = tos;
            w.total_length        = tot_len;
            w.ident               = ident;
            w.frag_flags          = flg_off[15:13];
            w.frag_offset         = flg_off[12:0];
            w.time_to_live        = ttl;
            w.protocol_number     = proto;
            w.source_address      = src;
            w.destination_address = dst;
            w.status              = st;
            return w;
        endfunction

        function void note_byte(ihpc_pkg::in_word_t w);
            logic [5:0]  p;
            logic [16:0] s;
            logic [7:0]  b;
            b = w.data_byte;
            if (w.start_of_packet)
            begin
                in_hdr   = 1'b1;
                pos      = '0;
                csum_acc = '0;
            end
            else if (!in_hdr)
                return;
            p = pos;
            // even byte is held, odd byte completes the 16-bit word
            if (!p[0])
                hi_byte = b;
            else
            begin
                s = {1'b0, csum_acc} + {1'b0, hi_byte, b};
                csum_acc = s[15:0] + 16'(s[16]);
            end
            case (p)
                0:              begin ver = b[7:4]; ihl = b[3:0]; end
                1:              tos = b;
                2, 3:           tot_len = {tot_len[7:0], b};
                4, 5:           ident = {ident[7:0], b};
                6, 7:           flg_off = {flg_off[7:0], b};
                8:              ttl = b;
                9:              proto = b;
                12, 13, 14, 15: src = {src[23:0], b};
                16, 17, 18, 19: dst = {dst[23:0], b};
                default:        ;
            endcase
            if (p == ihpc_pkg::POS_HDR_CHECK
                && (ver != ihpc_pkg::IP_VERSION || ihl < ihpc_pkg::MIN_IHL))
            begin
                in_hdr = 1'b0;
                headers_due.push_back(capture(ihpc_pkg::STATUS_BAD_HEADER));
                predicted++;
                return;
            end
            if (p >= ihpc_pkg::POS_HDR_CHECK && int'(p) == int'(ihl) * 4 - 1)
            begin
                in_hdr = 1'b0;
                headers_due.push_back(capture(csum_acc == ihpc_pkg::SUM_GOOD
                                              ? ihpc_pkg::STATUS_OK
                                              : ihpc_pkg::STATUS_BAD_CHECKSUM));
                predicted++;
                return;
            end
            pos = p + 6'd1;
        endfunction

        function void check_field(string name, logic [31:0] exp, logic [31:0] act);
            if (exp !== act)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
            end
        endfunction

        function void check_header(ihpc_pkg::out_word_t got);
            ihpc_pkg::out_word_t exp;
            if (headers_due.size() == 0)
            begin
                errors++;
                $display("%0t: header word with none expected, actual %h", $time, got);
                return;
            end
            exp = headers_due.pop_front();
            check_field("version", exp.version, got.version);
            check_field("header_words", exp.header_words, got.header_words);
            check_field("service_type", exp.service_type, got.service_type);
            check_field("total_length", exp.total_length, got.total_length);
            check_field("ident", exp.ident, got.ident);
            check_field("frag_flags", exp.frag_flags, got.frag_flags);
            check_field("frag_offset", exp.frag_offset, got.frag_offset);
            check_field("time_to_live", exp.time_to_live, got.time_to_live);
            check_field("protocol_number", exp.protocol_number, got.protocol_number);
            check_field("source_address", exp.source_address, got.source_address);
            check_field("destination_address", exp.destination_address,
                        got.destination_address);
            check_field("status", exp.status, got.status);
        endfunction

        function int pending();
            return headers_due.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                byte_valid;
    logic                byte_ready;
    ihpc_pkg::in_word_t  byte_word;
    logic                result_valid;
    logic                result_ready;
    ihpc_pkg::out_word_t result_word;

    header_scoreboard sb;
    int               idle_pct  = 0;
    int               stall_pct = 0;
    int               cycles    = 0;
    logic [7:0]       frame[$];
    int               hdr_len;
    int               hdr_sent;

    ipv4_header_parse_check i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_word    (byte_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
                sb.note_byte(byte_word);
            if (result_valid && result_ready)
                sb.check_header(result_word);
        end
    end

    always @(posedge clk)
        result_ready <= ($urandom_range(99) >= stall_pct);

    task automatic send_byte(input logic [7:0] b, input logic sop);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_word  <= '{data_byte: b, start_of_packet: sop};
        do
            @(posedge clk);
        while (!byte_ready);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_byte(frame[i], i == 0);
    endtask

    // lower valid and hold off until every header word has come back
    task automatic wait_idle();
        byte_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic ihpc_pkg::out_word_t random_fields();
        ihpc_pkg::out_word_t h;
        h.version             = ihpc_pkg::IP_VERSION;
        h.header_words        = ($urandom_range(9) < 7) ? 4'd5 : 4'($urandom_range(6, 15));
        h.service_type        = 8'($urandom_range(255));
        h.total_length        = 16'($urandom_range(65535));
        h.ident               = 16'($urandom_range(65535));
        h.frag_flags          = 3'($urandom_range(7));
        h.frag_offset         = 13'($urandom_range(8191));
        h.time_to_live        = 8'($urandom_range(255));
        h.protocol_number     = 8'($urandom_range(255));
        h.source_address      = $urandom;
        h.destination_address = $urandom;
        h.status              = ihpc_pkg::STATUS_OK;
        return h;
    endfunction

    // header bytes with a filled-in checksum, then tail payload bytes
    function automatic void build_frame(ihpc_pkg::out_word_t h, bit bad_sum, int tail);
        logic [16:0] acc;
        logic [15:0] chk;
        hdr_len = (h.header_words >= ihpc_pkg::MIN_IHL) ? 4 * h.header_words : 20;
        frame = {};
        frame.push_back({h.version, h.header_words});
        frame.push_back(h.service_type);
        frame.push_back(h.total_length[15:8]);
        frame.push_back(h.total_length[7:0]);
        frame.push_back(h.ident[15:8]);
        frame.push_back(h.ident[7:0]);
        frame.push_back({h.frag_flags, h.frag_offset[12:8]});
        frame.push_back(h.frag_offset[7:0]);
        frame.push_back(h.time_to_live);
        frame.push_back(h.protocol_number);
        frame.push_back(8'h00);
        frame.push_back(8'h00);
        for (int i = 3; i >= 0; i--)
            frame.push_back(h.source_address[8*i +: 8]);
        for (int i = 3; i >= 0; i--)
            frame.push_back(h.destination_address[8*i +: 8]);
        while (frame.size() < hdr_len)
            frame.push_back(8'($urandom_range(255)));
        acc = '0;
        for (int i = 0; i < hdr_len; i += 2)
        begin
            acc = acc + {1'b0, frame[i], frame[i+1]};
            acc = {1'b0, acc[15:0]} + {16'd0, acc[16]};
        end
        chk = ~acc[15:0];
        if (bad_sum)
            chk ^= 16'd1 << $urandom_range(15);
        frame[10] = chk[15:8];
        frame[11] = chk[7:0];
        repeat (tail) frame.push_back(8'($urandom_range(255)));
    endfunction

    task automatic random_frame();
        ihpc_pkg::out_word_t h;
        int                  kind;
        int                  cut;
        h = random_fields();
        kind = $urandom_range(99);
        // stray bytes with no start flag
        if (kind >= 94)
        begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
            return;
        end
        if (kind >= 77 && kind < 85)
        begin
            h.version      = 4'($urandom_range(15));
            h.header_words = 4'($urandom_range(15));
            if (h.version == ihpc_pkg::IP_VERSION && h.header_words >= ihpc_pkg::MIN_IHL)
                h.header_words = 4'($urandom_range(4));
        end
        build_frame(h, kind >= 65 && kind < 77, $urandom_range(3));
        // cut short, the next start flag drops it
        if (kind >= 85)
        begin
            cut = $urandom_range(1, hdr_len - 1);
            frame = frame[0:cut-1];
        end
        hdr_sent += (frame.size() < hdr_len) ? frame.size() : hdr_len;
        send_frame();
    endtask

    initial
    begin
        ihpc_pkg::out_word_t h;
        int                  base;
        int                  idles[4]  = '{0, 81, 0, 33};
        int                  stalls[4] = '{0, 0, 81, 33};

        sb = new();
        rst_n        <= 1'b0;
        byte_valid   <= 1'b0;
        byte_word    <= '0;
        result_ready <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bytes while idle are dropped
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h45, 1'b0);

        h = '0;
        h.version = ihpc_pkg::IP_VERSION;
        h.header_words = ihpc_pkg::MIN_IHL;
        build_frame(h, 1'b0, 0);
        send_frame();

        h = '1;
        h.version = ihpc_pkg::IP_VERSION;
        build_frame(h, 1'b0, 0);
        send_frame();
        build_frame(h, 1'b1, 2);
        send_frame();

        // wrong version, then ihl too small
        h = random_fields();
        h.version = 4'd6;
        h.header_words = ihpc_pkg::MIN_IHL;
        build_frame(h, 1'b0, 0);
        send_frame();
        h = random_fields();
        h.header_words = 4'd0;
        build_frame(h, 1'b0, 0);
        send_frame();
        h.header_words = 4'd4;
        build_frame(h, 1'b0, 1);
        send_frame();

        // bad version with a full-length header, the rest of the header is ignored
        h = '1;
        build_frame(h, 1'b0, 0);
        send_frame();

        // restart in mid-header at several depths
        h = random_fields();
        build_frame(h, 1'b0, 0);
        frame = frame[0:9];
        send_frame();
        build_frame(h, 1'b0, 0);
        frame = frame[0:18];
        send_frame();
        h.header_words = 4'd6;
        build_frame(h, 1'b0, 0);
        frame = frame[0:19];
        send_frame();
        send_byte(8'h45, 1'b1);
        send_byte(8'h45, 1'b1);

        // total length shorter than the header
        h = random_fields();
        h.total_length = 16'd3;
        build_frame(h, 1'b0, 4);
        send_frame();
        h = random_fields();
        build_frame(h, 1'b0, 0);
        send_frame();
        wait_idle();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = idles[ph];
            stall_pct = stalls[ph];
            hdr_sent  = 0;
            base      = sb.predicted;
            while (hdr_sent < HDR_BYTES_PER_PHASE || sb.predicted - base < HEADERS_PER_PHASE)
                random_frame();
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ihpc_pkg.sv
hw/rtl/ihpc_parser.sv
hw/rtl/ihpc_out_stage.sv
hw/rtl/ipv4_header_parse_check.sv
dv/tb_ipv4_header_parse_check.sv
